// File: rtl/core/mcpwm_pkg.sv
// shared types and constants for the multi-channel pwm block
// no dependencies; used by the channel interfaces and the top level
package mcpwm_pkg;

    localparam int unsigned CMD_W     = 1;
    localparam int unsigned CH_W      = 3;
    localparam int unsigned TICK_W    = 10;
    localparam int unsigned PIN_W     = 8;

    localparam int unsigned DEFAULT_CHANNELS = 8;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [TICK_W-1:0] t_ticks;
    typedef logic [PIN_W-1:0]  t_pins;

    localparam t_cmd   CMD_TICK     = 1'b0;
    localparam t_cmd   CMD_SET_DUTY = 1'b1;

    localparam t_ticks PERIOD_RESET = 10'd100;

endpackage

// File: rtl/core/mcpwm_if.sv
// valid/ready channel interfaces for command beats and result beats
// depends on mcpwm_pkg for the payload types
interface mcpwm_cmd_if;
    logic                valid;
    logic                ready;
    mcpwm_pkg::t_cmd     command;
    mcpwm_pkg::t_chan    channel;
    mcpwm_pkg::t_ticks   duty_value;

    modport source (output valid, output command, output channel, output duty_value,
                    input ready);
    modport sink   (input valid, input command, input channel, input duty_value,
                    output ready);
endinterface

interface mcpwm_res_if;
    logic                valid;
    logic                ready;
    mcpwm_pkg::t_pins    pin_levels;
    mcpwm_pkg::t_ticks   tick_position;

    modport source (output valid, output pin_levels, output tick_position, input ready);
    modport sink   (input valid, input pin_levels, input tick_position, output ready);
endinterface

// File: rtl/core/multi_channel_pwm_with_parity_alignment.sv
// multi-channel pwm with shared period counter, odd channels end-aligned
// the result beat turns valid in the cycle after the command beat is accepted
// throughput: one command beat per cycle while results are taken
// the counter and level registers double as the result register
// reset (sync, active low): counter 0, duties 0, levels low, period 100
// depends on mcpwm_pkg and the interfaces in mcpwm_if.sv
module multi_channel_pwm_with_parity_alignment #(
    parameter int unsigned CHANNELS = mcpwm_pkg::DEFAULT_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  mcpwm_pkg::t_ticks i_cfg_wr_data,
    mcpwm_cmd_if.sink         i_cmd,
    mcpwm_res_if.source       o_res
);
    import mcpwm_pkg::*;

    // only channels reachable by the channel field are stored
    localparam int unsigned NUM_ADDR = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;

    t_ticks r_period;
    t_ticks r_counter;
    t_ticks n_counter;
    t_pins  r_level;
    t_pins  n_level;
    t_ticks r_duty [NUM_ADDR];
    logic   r_out_valid;

    logic   accept;
    logic   is_tick;
    logic   is_set;
    logic [TICK_W:0] cnt_inc;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign is_tick     = accept && (i_cmd.command == CMD_TICK);
    assign is_set      = accept && (i_cmd.command == CMD_SET_DUTY);

    // wrap once the incremented count reaches the period
    always_comb begin
        cnt_inc = {1'b0, r_counter} + 11'd1;
        if (cnt_inc >= {1'b0, r_period}) begin
            n_counter = '0;
        end else begin
            n_counter = cnt_inc[TICK_W-1:0];
        end
    end

    always_comb begin
        n_level = '0;
        for (int i = 0; i < NUM_ADDR; i++) begin
            if (r_duty[i] == '0) begin
                n_level[i] = 1'b0;
            end else if (r_duty[i] >= r_period) begin
                n_level[i] = 1'b1;
            end else if (i % 2 == 1) begin
                // end-aligned pulse for odd channels
                n_level[i] = (n_counter >= (r_period - r_duty[i]));
            end else begin
                n_level[i] = (n_counter < r_duty[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_level   <= '0;
        end else if (is_tick) begin
            r_counter <= n_counter;
            r_level   <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ADDR; i++) begin
                r_duty[i] <= '0;
            end
        end else if (is_set) begin
            for (int i = 0; i < NUM_ADDR; i++) begin
                if (i_cmd.channel == CH_W'(i)) begin
                    r_duty[i] <= i_cmd.duty_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.pin_levels    = r_level;
    assign o_res.tick_position = r_counter;

    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_res.valid)
        else $error("accepted beat produced no result");

    a_set_keeps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_set |=> ($stable(r_counter) && $stable(r_level)))
        else $error("set-duty beat changed counter or levels");

    a_counter_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_tick |=> (r_counter == '0 || r_counter < $past(r_period)))
        else $error("counter left the period after a tick");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule
